// ----- src/sdm_pkg.sv -----
// Shared widths, constants, word types and the LLR round/saturate function of the soft demapper.
package sdm_pkg;

    // Symbol and LLR formats: I/Q in Q2.13, LLR in Q5.10
    localparam int IQ_W     = 16;
    localparam int LLR_W    = 16;
    localparam int IQ_FRAC  = IQ_W - 3;
    localparam int LLR_FRAC = LLR_W - 6;
    localparam int KFRAC    = 20;
    localparam int WFRAC    = IQ_FRAC + KFRAC;
    localparam int RND_SH   = WFRAC - LLR_FRAC;

    // Multiplier operand, coefficient and product widths
    localparam int OP_W = IQ_W + 2;
    localparam int K_W  = 23;
    localparam int W_W  = OP_W + K_W + 1;
    localparam int R_W  = W_W - RND_SH;
    localparam int CNT_W = 3;

    // Coefficients in Q.20
    localparam logic signed [K_W-1:0] K_INV_SQRT2 = K_W'(741455);
    localparam logic signed [K_W-1:0] K_SQRT2     = K_W'(1482910);
    localparam logic signed [K_W-1:0] K_SQRT10    = K_W'(3315888);
    localparam logic signed [K_W-1:0] K_SQRT10_3  = K_W'(1105296);
    localparam logic signed [K_W-1:0] K_ONE       = K_W'(64'sd1 <<< KFRAC);

    // Offsets at the product scale (WFRAC fraction bits)
    localparam logic signed [W_W-1:0] OFF_QAM16 = W_W'(64'sd2 <<< WFRAC);
    localparam logic signed [W_W-1:0] OFF_QAM64 = W_W'(64'sd647195 <<< IQ_FRAC);
    localparam logic signed [W_W-1:0] OFF_INNER = W_W'(64'sd323598 <<< IQ_FRAC);
    localparam logic signed [W_W-1:0] RND_HALF  = W_W'(64'sd1 <<< (RND_SH - 1));

    localparam logic signed [LLR_W-1:0] LLR_MAX = {1'b0, {(LLR_W-1){1'b1}}};
    localparam logic signed [LLR_W-1:0] LLR_MIN = {1'b1, {(LLR_W-1){1'b0}}};
    localparam logic signed [R_W-1:0]   R_HI    = R_W'(LLR_MAX);
    localparam logic signed [R_W-1:0]   R_LO    = R_W'(LLR_MIN);

    localparam logic [CNT_W-1:0] CNT_BPSK  = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_QPSK  = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_QAM16 = CNT_W'(4);
    localparam logic [CNT_W-1:0] CNT_QAM64 = CNT_W'(6);

    typedef enum logic [1:0] {
        MOD_BPSK  = 2'd0,
        MOD_QPSK  = 2'd1,
        MOD_QAM16 = 2'd2,
        MOD_QAM64 = 2'd3
    } mod_t;

    typedef struct packed {
        logic signed [IQ_W-1:0] re;
        logic signed [IQ_W-1:0] im;
        logic                   last;
        mod_t                   mode;
    } sym_t;

    // One axis ahead of the multipliers
    typedef struct packed {
        logic signed [OP_W-1:0] sop;
        logic signed [K_W-1:0]  ks;
        logic signed [OP_W-1:0] mag;
        logic signed [K_W-1:0]  ka;
        logic                   neg;
    } opl_t;

    typedef struct packed {
        opl_t [1:0] lane;
        logic       last;
        mod_t       mode;
    } opnd_t;

    typedef struct packed {
        logic signed [W_W-1:0] ps;
        logic signed [W_W-1:0] pa;
        logic                  neg;
    } prl_t;

    typedef struct packed {
        prl_t [1:0] lane;
        logic       last;
        mod_t       mode;
    } prod_t;

    typedef struct packed {
        logic signed [W_W-1:0] s;
        logic signed [W_W-1:0] a;
    } acl_t;

    typedef struct packed {
        acl_t [1:0] lane;
        logic       last;
        mod_t       mode;
    } acc_t;

    typedef struct packed {
        logic signed [W_W-1:0] s;
        logic signed [W_W-1:0] a;
        logic signed [W_W-1:0] b;
    } fnl_t;

    typedef struct packed {
        fnl_t [1:0] lane;
        logic       last;
        mod_t       mode;
    } fin_t;

    // Round half up to LLR_FRAC fraction bits, then clamp to the LLR range
    function automatic logic signed [LLR_W-1:0] to_llr(input logic signed [W_W-1:0] w);
        logic signed [W_W-1:0]   t;
        logic signed [R_W-1:0]   r;
        logic signed [LLR_W-1:0] res;
        t = w + RND_HALF;
        r = R_W'(t >>> RND_SH);
        if (r > R_HI) begin
            res = LLR_MAX;
        end else if (r < R_LO) begin
            res = LLR_MIN;
        end else begin
            res = LLR_W'(r);
        end
        return res;
    endfunction

endpackage

// ----- src/soft_demapper_bpsk_to_64qam.sv -----
// Top level of the max-log soft demapper for BPSK, QPSK, 16QAM and 64QAM.
//
// Usage:
//   Input channel: one equalized symbol per word (sym_re, sym_im in signed Q2.13,
//   plus last_in), taken at a rising edge where in_valid is high and in_stall low.
//   Output channel: one word of soft bits per symbol (llr_0..llr_5 in signed
//   Q5.10, saturated; llr_count = 1, 2, 4 or 6; last_out copies last_in), taken
//   where out_valid is high and out_stall low. LLRs past llr_count read zero.
//   Configuration: cfg_wr_en writes cfg_wr_data into the modulation register
//   (0 BPSK, 1 QPSK, 2 16QAM, 3 64QAM). Write it only while the pipe is empty.
// Timing:
//   Six register stages: input, operand prep, multiply, offset/slope select,
//   inner distance, round/saturate, in that order. Throughput is one word per
//   clock while out_stall is low; the one multiply per axis and product sits
//   alone in its own stage.
// Reset and stall:
//   Reset empties every stage and sets the modulation to QPSK. A stall from the
//   receiver holds the output word; each earlier stage keeps advancing into
//   empty slots ahead of it, so bubbles close up before in_stall is raised.
module soft_demapper_bpsk_to_64qam (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [sdm_pkg::IQ_W-1:0]   sym_re,
    input  logic signed [sdm_pkg::IQ_W-1:0]   sym_im,
    input  logic                              last_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [sdm_pkg::LLR_W-1:0]  llr_0,
    output logic signed [sdm_pkg::LLR_W-1:0]  llr_1,
    output logic signed [sdm_pkg::LLR_W-1:0]  llr_2,
    output logic signed [sdm_pkg::LLR_W-1:0]  llr_3,
    output logic signed [sdm_pkg::LLR_W-1:0]  llr_4,
    output logic signed [sdm_pkg::LLR_W-1:0]  llr_5,
    output logic [sdm_pkg::CNT_W-1:0]         llr_count,
    output logic                              last_out
);

    sdm_pkg::mod_t   mode_reg;

    logic            opnd_valid;
    logic            opnd_stall;
    sdm_pkg::opnd_t  opnd;
    logic            prod_valid;
    logic            prod_stall;
    sdm_pkg::prod_t  prod;
    logic            fin_valid;
    logic            fin_stall;
    sdm_pkg::fin_t   fin;

    // Modulation register; the mode travels with each word from the input stage on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= sdm_pkg::MOD_QPSK;
        end else if (cfg_wr_en) begin
            mode_reg <= sdm_pkg::mod_t'(cfg_wr_data);
        end
    end

    // Capture the symbol, then form negated, magnitude and sum operands
    sdm_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sym_re     (sym_re),
        .sym_im     (sym_im),
        .last_in    (last_in),
        .mode       (mode_reg),
        .opnd_valid (opnd_valid),
        .opnd       (opnd),
        .opnd_stall (opnd_stall)
    );

    // Scale by the modulation's coefficients
    sdm_mult u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .opnd_valid (opnd_valid),
        .opnd       (opnd),
        .opnd_stall (opnd_stall),
        .prod_valid (prod_valid),
        .prod       (prod),
        .prod_stall (prod_stall)
    );

    // Amplitude offset, 16QAM slope choice, then the 64QAM inner distance
    sdm_post u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .prod_valid (prod_valid),
        .prod       (prod),
        .prod_stall (prod_stall),
        .fin_valid  (fin_valid),
        .fin        (fin),
        .fin_stall  (fin_stall)
    );

    // Round to Q5.10, clamp, zero unused soft bits and hold the output word
    sdm_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid),
        .fin       (fin),
        .fin_stall (fin_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .llr_0     (llr_0),
        .llr_1     (llr_1),
        .llr_2     (llr_2),
        .llr_3     (llr_3),
        .llr_4     (llr_4),
        .llr_5     (llr_5),
        .llr_count (llr_count),
        .last_out  (last_out)
    );

endmodule

// ----- src/sdm_prep.sv -----
// Input register and operand preparation stage of the soft demapper.
module sdm_prep (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [sdm_pkg::IQ_W-1:0]   sym_re,
    input  logic signed [sdm_pkg::IQ_W-1:0]   sym_im,
    input  logic                              last_in,
    input  sdm_pkg::mod_t                     mode,
    output logic                              opnd_valid,
    output sdm_pkg::opnd_t                    opnd,
    input  logic                              opnd_stall
);

    logic            s1_v_reg;
    sdm_pkg::sym_t   s1_reg;
    logic            s1_stall;
    logic            s2_v_reg;
    sdm_pkg::opnd_t  s2_reg;
    sdm_pkg::opnd_t  s2_next;
    logic            s2_stall;

    assign s2_stall = s2_v_reg & opnd_stall;
    assign s1_stall = s1_v_reg & s2_stall;
    assign in_stall = s1_stall;

    always_comb
    begin
        logic signed [sdm_pkg::OP_W-1:0] y [2];
        logic signed [sdm_pkg::OP_W-1:0] sum_n;
        y[0]  = sdm_pkg::OP_W'($signed(s1_reg.re));
        y[1]  = sdm_pkg::OP_W'($signed(s1_reg.im));
        sum_n = -(y[0] + y[1]);
        s2_next.last = s1_reg.last;
        s2_next.mode = s1_reg.mode;
        for (int k = 0; k < 2; k++) begin
            s2_next.lane[k].neg = y[k][sdm_pkg::OP_W-1];
            s2_next.lane[k].mag = y[k][sdm_pkg::OP_W-1] ? -y[k] : y[k];
            s2_next.lane[k].sop = -y[k];
            unique case (s1_reg.mode)
                sdm_pkg::MOD_BPSK:
                begin
                    // single LLR from the sum of both axes
                    s2_next.lane[k].sop = (k == 0) ? sum_n : '0;
                    s2_next.lane[k].ks  = sdm_pkg::K_INV_SQRT2;
                    s2_next.lane[k].ka  = '0;
                end
                sdm_pkg::MOD_QPSK:
                begin
                    s2_next.lane[k].ks = sdm_pkg::K_SQRT2;
                    s2_next.lane[k].ka = '0;
                end
                sdm_pkg::MOD_QAM16:
                begin
                    s2_next.lane[k].ks = sdm_pkg::K_SQRT10_3;
                    s2_next.lane[k].ka = sdm_pkg::K_SQRT10;
                end
                default:
                begin
                    s2_next.lane[k].ks = sdm_pkg::K_ONE;
                    s2_next.lane[k].ka = sdm_pkg::K_ONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end else begin
            if (!s1_stall) begin
                s1_v_reg <= in_valid;
            end
            if (!s2_stall) begin
                s2_v_reg <= s1_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s1_stall) begin
            s1_reg.re   <= sym_re;
            s1_reg.im   <= sym_im;
            s1_reg.last <= last_in;
            s1_reg.mode <= mode;
        end
        if (!s2_stall) begin
            s2_reg <= s2_next;
        end
    end

    assign opnd_valid = s2_v_reg;
    assign opnd       = s2_reg;

endmodule

// ----- src/sdm_mult.sv -----
// Multiplier stage: sign and amplitude products for both axes.
module sdm_mult (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            opnd_valid,
    input  sdm_pkg::opnd_t  opnd,
    output logic            opnd_stall,
    output logic            prod_valid,
    output sdm_pkg::prod_t  prod,
    input  logic            prod_stall
);

    logic            v_reg;
    sdm_pkg::prod_t  p_reg;
    sdm_pkg::prod_t  p_next;
    logic            stall;

    assign stall      = v_reg & prod_stall;
    assign opnd_stall = stall;

    always_comb
    begin
        p_next.last = opnd.last;
        p_next.mode = opnd.mode;
        for (int k = 0; k < 2; k++) begin
            p_next.lane[k].ps  = sdm_pkg::W_W'($signed(opnd.lane[k].sop)
                                 * $signed(opnd.lane[k].ks));
            p_next.lane[k].pa  = sdm_pkg::W_W'($signed(opnd.lane[k].mag)
                                 * $signed(opnd.lane[k].ka));
            p_next.lane[k].neg = opnd.lane[k].neg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= 1'b0;
        end else if (!stall) begin
            v_reg <= opnd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall) begin
            p_reg <= p_next;
        end
    end

    assign prod_valid = v_reg;
    assign prod       = p_reg;

endmodule

// ----- src/sdm_post.sv -----
// Offset, slope select and inner-distance stages of the soft demapper.
module sdm_post (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            prod_valid,
    input  sdm_pkg::prod_t  prod,
    output logic            prod_stall,
    output logic            fin_valid,
    output sdm_pkg::fin_t   fin,
    input  logic            fin_stall
);

    logic            s4_v_reg;
    sdm_pkg::acc_t   s4_reg;
    sdm_pkg::acc_t   s4_next;
    logic            s4_stall;
    logic            s5_v_reg;
    sdm_pkg::fin_t   s5_reg;
    sdm_pkg::fin_t   s5_next;
    logic            s5_stall;

    assign s5_stall   = s5_v_reg & fin_stall;
    assign s4_stall   = s4_v_reg & s5_stall;
    assign prod_stall = s4_stall;

    // Subtract the amplitude offset; pick the 16QAM sign slope on the exact product
    always_comb
    begin
        logic signed [sdm_pkg::W_W-1:0] off;
        logic                           outer;
        off = (prod.mode == sdm_pkg::MOD_QAM64) ? sdm_pkg::OFF_QAM64 : sdm_pkg::OFF_QAM16;
        s4_next.last = prod.last;
        s4_next.mode = prod.mode;
        for (int k = 0; k < 2; k++) begin
            outer = prod.lane[k].pa > off;
            s4_next.lane[k].a = prod.lane[k].pa - off;
            if (prod.mode == sdm_pkg::MOD_QAM16 && !outer) begin
                s4_next.lane[k].s = prod.lane[k].neg ? prod.lane[k].pa : -prod.lane[k].pa;
            end else begin
                s4_next.lane[k].s = prod.lane[k].ps;
            end
        end
    end

    // Inner distance |a| - 2/sqrt42; for negative a this is ~a - (off - 1)
    always_comb
    begin
        s5_next.last = s4_reg.last;
        s5_next.mode = s4_reg.mode;
        for (int k = 0; k < 2; k++) begin
            s5_next.lane[k].s = s4_reg.lane[k].s;
            s5_next.lane[k].a = s4_reg.lane[k].a;
            if (s4_reg.lane[k].a[sdm_pkg::W_W-1]) begin
                s5_next.lane[k].b = (~s4_reg.lane[k].a)
                                    - (sdm_pkg::OFF_INNER - sdm_pkg::W_W'(1));
            end else begin
                s5_next.lane[k].b = s4_reg.lane[k].a - sdm_pkg::OFF_INNER;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
        end else begin
            if (!s4_stall) begin
                s4_v_reg <= prod_valid;
            end
            if (!s5_stall) begin
                s5_v_reg <= s4_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s4_stall) begin
            s4_reg <= s4_next;
        end
        if (!s5_stall) begin
            s5_reg <= s5_next;
        end
    end

    assign fin_valid = s5_v_reg;
    assign fin       = s5_reg;

endmodule

// ----- src/sdm_round.sv -----
// Round, saturate and output register stage of the soft demapper.
module sdm_round (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              fin_valid,
    input  sdm_pkg::fin_t                     fin,
    output logic                              fin_stall,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [sdm_pkg::LLR_W-1:0]  llr_0,
    output logic signed [sdm_pkg::LLR_W-1:0]  llr_1,
    output logic signed [sdm_pkg::LLR_W-1:0]  llr_2,
    output logic signed [sdm_pkg::LLR_W-1:0]  llr_3,
    output logic signed [sdm_pkg::LLR_W-1:0]  llr_4,
    output logic signed [sdm_pkg::LLR_W-1:0]  llr_5,
    output logic [sdm_pkg::CNT_W-1:0]         llr_count,
    output logic                              last_out
);

    logic                              v_reg;
    logic                              stall;
    logic signed [sdm_pkg::LLR_W-1:0]  llr_reg  [6];
    logic signed [sdm_pkg::LLR_W-1:0]  llr_next [6];
    logic [sdm_pkg::CNT_W-1:0]         cnt_reg;
    logic [sdm_pkg::CNT_W-1:0]         cnt_next;
    logic                              last_reg;

    assign stall     = v_reg & out_stall;
    assign fin_stall = stall;

    always_comb
    begin
        for (int i = 0; i < 6; i++) begin
            llr_next[i] = '0;
        end
        unique case (fin.mode)
            sdm_pkg::MOD_BPSK:
            begin
                llr_next[0] = sdm_pkg::to_llr(fin.lane[0].s);
                cnt_next    = sdm_pkg::CNT_BPSK;
            end
            sdm_pkg::MOD_QPSK:
            begin
                llr_next[0] = sdm_pkg::to_llr(fin.lane[0].s);
                llr_next[1] = sdm_pkg::to_llr(fin.lane[1].s);
                cnt_next    = sdm_pkg::CNT_QPSK;
            end
            sdm_pkg::MOD_QAM16:
            begin
                llr_next[0] = sdm_pkg::to_llr(fin.lane[0].s);
                llr_next[1] = sdm_pkg::to_llr(fin.lane[1].s);
                llr_next[2] = sdm_pkg::to_llr(fin.lane[0].a);
                llr_next[3] = sdm_pkg::to_llr(fin.lane[1].a);
                cnt_next    = sdm_pkg::CNT_QAM16;
            end
            default:
            begin
                llr_next[0] = sdm_pkg::to_llr(fin.lane[0].s);
                llr_next[1] = sdm_pkg::to_llr(fin.lane[1].s);
                llr_next[2] = sdm_pkg::to_llr(fin.lane[0].a);
                llr_next[3] = sdm_pkg::to_llr(fin.lane[1].a);
                llr_next[4] = sdm_pkg::to_llr(fin.lane[0].b);
                llr_next[5] = sdm_pkg::to_llr(fin.lane[1].b);
                cnt_next    = sdm_pkg::CNT_QAM64;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= 1'b0;
        end else if (!stall) begin
            v_reg <= fin_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall) begin
            for (int i = 0; i < 6; i++) begin
                llr_reg[i] <= llr_next[i];
            end
            cnt_reg  <= cnt_next;
            last_reg <= fin.last;
        end
    end

    assign out_valid = v_reg;
    assign llr_0     = llr_reg[0];
    assign llr_1     = llr_reg[1];
    assign llr_2     = llr_reg[2];
    assign llr_3     = llr_reg[3];
    assign llr_4     = llr_reg[4];
    assign llr_5     = llr_reg[5];
    assign llr_count = cnt_reg;
    assign last_out  = last_reg;

endmodule

// ----- tb/soft_demapper_bpsk_to_64qam_tb.sv -----
// Self-checking testbench for the max-log soft demapper, all four modulations.
module soft_demapper_bpsk_to_64qam_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Q.20 coefficients of the demapping rules
    localparam longint Q_INV_SQRT2 = 64'sd741455;
    localparam longint Q_SQRT2     = 64'sd1482910;
    localparam longint Q_SQRT10    = 64'sd3315888;
    localparam longint Q_SQRT10_3  = 64'sd1105296;
    localparam longint Q_4_SQRT42  = 64'sd647195;
    localparam longint Q_2_SQRT42  = 64'sd323598;
    localparam longint Q_ONE       = 64'sd1 <<< sdm_pkg::KFRAC;

    // Receiver hold-off: word counts at which it goes quiet, and for how long
    localparam int HOLD_AT_A  = 600;
    localparam int HOLD_AT_B  = 1600;
    localparam int HOLD_LEN   = 150;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 250;
    localparam int DRAIN_WAIT = 20;

    // One output word: six soft bits, their count and the block-end flag
    typedef struct packed {
        logic [0:5][sdm_pkg::LLR_W-1:0] llr;
        logic [sdm_pkg::CNT_W-1:0]      cnt;
        logic                           last;
    } soft_word_t;

    // One row of the directed table; want is only used where typed is set
    typedef struct {
        sdm_pkg::mod_t                   mode;
        logic signed [sdm_pkg::IQ_W-1:0] re;
        logic signed [sdm_pkg::IQ_W-1:0] im;
        logic                            last;
        bit                              typed;
        soft_word_t                      want;
    } sym_row_t;

    logic                              clk         = 1'b0;
    logic                              rst_n       = 1'b0;
    logic                              cfg_wr_en   = 1'b0;
    logic [1:0]                        cfg_wr_data = 2'd0;
    logic                              in_valid    = 1'b0;
    logic                              in_stall;
    logic signed [sdm_pkg::IQ_W-1:0]   sym_re      = '0;
    logic signed [sdm_pkg::IQ_W-1:0]   sym_im      = '0;
    logic                              last_in     = 1'b0;
    logic                              out_valid;
    logic                              out_stall   = 1'b0;
    logic signed [sdm_pkg::LLR_W-1:0]  llr_0, llr_1, llr_2, llr_3, llr_4, llr_5;
    logic [sdm_pkg::CNT_W-1:0]         llr_count;
    logic                              last_out;

    // Modulation the block holds right now, as the testbench knows it
    sdm_pkg::mod_t mod_cfg = sdm_pkg::MOD_QPSK;
    soft_word_t    soft_bits_due[$];
    int            n_fail = 0;
    bit            send_burst = 1'b0;

    soft_demapper_bpsk_to_64qam dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sym_re     (sym_re),
        .sym_im     (sym_im),
        .last_in    (last_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .llr_0      (llr_0),
        .llr_1      (llr_1),
        .llr_2      (llr_2),
        .llr_3      (llr_3),
        .llr_4      (llr_4),
        .llr_5      (llr_5),
        .llr_count  (llr_count),
        .last_out   (last_out)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Hard stop: far beyond the slowest correct run
    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    // Round a product (WFRAC fraction bits) half up to LLR_FRAC bits, then clamp.
    // An arithmetic shift of a signed 64-bit value is a floor, which is what we want.
    function automatic logic [sdm_pkg::LLR_W-1:0] round_sat(longint w);
        longint r;
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (sdm_pkg::LLR_W - 1)) - 1;
        lo = -(64'sd1 <<< (sdm_pkg::LLR_W - 1));
        r  = (w + (64'sd1 <<< (sdm_pkg::RND_SH - 1))) >>> sdm_pkg::RND_SH;
        if (r > hi)
            r = hi;
        if (r < lo)
            r = lo;
        return r[sdm_pkg::LLR_W-1:0];
    endfunction

    // Soft bits of one symbol under modulation m; unused LLRs stay zero
    function automatic soft_word_t predict_soft_bits(sdm_pkg::mod_t m,
                                                     logic signed [sdm_pkg::IQ_W-1:0] re,
                                                     logic signed [sdm_pkg::IQ_W-1:0] im,
                                                     logic last);
        longint     y[2];
        longint     a;
        longint     b;
        soft_word_t w;
        y[0]   = longint'(re);
        y[1]   = longint'(im);
        w      = '0;
        w.last = last;
        case (m)
            sdm_pkg::MOD_BPSK:
            begin
                w.llr[0] = round_sat(-(y[0] + y[1]) * Q_INV_SQRT2);
                w.cnt    = sdm_pkg::CNT_BPSK;
            end
            sdm_pkg::MOD_QPSK:
            begin
                for (int k = 0; k < 2; k++)
                    w.llr[k] = round_sat(-y[k] * Q_SQRT2);
                w.cnt = sdm_pkg::CNT_QPSK;
            end
            sdm_pkg::MOD_QAM16:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    // The slope of the sign bit follows the exact amplitude distance
                    a = (y[k] < 0 ? -y[k] : y[k]) * Q_SQRT10 - (64'sd2 <<< sdm_pkg::WFRAC);
                    w.llr[k + 2] = round_sat(a);
                    w.llr[k] = round_sat(-y[k] * (a > 0 ? Q_SQRT10_3 : Q_SQRT10));
                end
                w.cnt = sdm_pkg::CNT_QAM16;
            end
            default:
            begin
                for (int k = 0; k < 2; k++)
                begin
                    a = (y[k] < 0 ? -y[k] : y[k]) * Q_ONE
                        - (Q_4_SQRT42 <<< sdm_pkg::IQ_FRAC);
                    b = (a < 0 ? -a : a) - (Q_2_SQRT42 <<< sdm_pkg::IQ_FRAC);
                    w.llr[k]     = round_sat(-y[k] * Q_ONE);
                    w.llr[k + 2] = round_sat(a);
                    w.llr[k + 4] = round_sat(b);
                end
                w.cnt = sdm_pkg::CNT_QAM64;
            end
        endcase
        return w;
    endfunction

    // Random axis value: full range, near a decision boundary, a corner, or a typical level
    function automatic logic signed [sdm_pkg::IQ_W-1:0] pick_axis();
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        if (sel < 4)
        begin
            v = $urandom;
        end
        else if (sel < 7)
        begin
            case ($urandom_range(0, 4))
                0: v = 5056;
                1: v = 5181;
                2: v = 2528;
                3: v = 7584;
                default: v = 0;
            endcase
            v = v + $urandom_range(0, 80) - 40;
            if ($urandom_range(0, 1))
                v = -v;
        end
        else if (sel < 8)
        begin
            case ($urandom_range(0, 4))
                0: v = -32768;
                1: v = 32767;
                2: v = 0;
                3: v = -1;
                default: v = 1;
            endcase
        end
        else
        begin
            v = $urandom_range(0, 12000);
            if ($urandom_range(0, 1))
                v = -v;
        end
        return sdm_pkg::IQ_W'(v);
    endfunction

    task automatic note_fail(string what, longint want_v, longint got_v);
        n_fail++;
        if (n_fail <= 10)
            $display("%0t: %s expected %0d got %0d", $realtime, what, want_v, got_v);
    endtask

    // Write the modulation register once the pipe has drained.
    // Call at a falling edge; drop valid first so the last word is not offered again.
    task automatic write_modulation(sdm_pkg::mod_t m);
        in_valid <= 1'b0;
        while (soft_bits_due.size() != 0)
            @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        mod_cfg    = m;
    endtask

    // Offer one symbol word after a random gap and hold it until taken.
    // Call at a falling edge; return at the falling edge after acceptance.
    task automatic send_symbol(logic signed [sdm_pkg::IQ_W-1:0] re,
                               logic signed [sdm_pkg::IQ_W-1:0] im,
                               logic last, bit typed, soft_word_t want);
        int gap;
        if ($urandom_range(0, 39) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sym_re   <= re;
        sym_im   <= im;
        last_in  <= last;
        // Hold the word until an edge where the block does not stall
        do
            @(posedge clk);
        while (in_stall);
        soft_bits_due.push_back(typed ? want : predict_soft_bits(mod_cfg, re, im, last));
        @(negedge clk);
    endtask

    // Stimulus: reset, directed table, then random phases over all modulations
    initial
    begin
        sym_row_t      dir_tab[$];
        sdm_pkg::mod_t m;
        soft_word_t    none;

        none = '0;
        // Rows are grouped by mode, so each later modulation is written once here.
        // The first rows run on the reset value of the register.
        dir_tab = '{
            '{sdm_pkg::MOD_QPSK, 16'sd0, 16'sd0, 1'b0, 1'b1,
              '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
                sdm_pkg::CNT_QPSK, 1'b0}},
            '{sdm_pkg::MOD_QPSK, 16'sh8000, 16'sh8000, 1'b1, 1'b1,
              '{'{16'sd5793, 16'sd5793, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
                sdm_pkg::CNT_QPSK, 1'b1}},
            '{sdm_pkg::MOD_QPSK, 16'sh7fff, -16'sd1, 1'b0, 1'b0, none},
            '{sdm_pkg::MOD_QPSK, 16'sd1, 16'sh7fff, 1'b1, 1'b0, none},
            '{sdm_pkg::MOD_BPSK, 16'sd0, 16'sd0, 1'b0, 1'b1,
              '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
                sdm_pkg::CNT_BPSK, 1'b0}},
            '{sdm_pkg::MOD_BPSK, 16'sh8000, 16'sh8000, 1'b0, 1'b1,
              '{'{16'sd5793, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
                sdm_pkg::CNT_BPSK, 1'b0}},
            '{sdm_pkg::MOD_BPSK, 16'sh7fff, 16'sh7fff, 1'b1, 1'b0, none},
            '{sdm_pkg::MOD_BPSK, 16'sh7fff, 16'sh8000, 1'b0, 1'b0, none},
            // 16QAM slope switch lies between 5181 and 5182
            '{sdm_pkg::MOD_QAM16, 16'sd5181, -16'sd5181, 1'b0, 1'b0, none},
            '{sdm_pkg::MOD_QAM16, 16'sd5182, -16'sd5182, 1'b0, 1'b0, none},
            '{sdm_pkg::MOD_QAM16, 16'sh8000, 16'sh7fff, 1'b1, 1'b0, none},
            '{sdm_pkg::MOD_QAM16, 16'sd0, 16'sd0, 1'b0, 1'b1,
              '{'{16'sd0, 16'sd0, -16'sd2048, -16'sd2048, 16'sd0, 16'sd0},
                sdm_pkg::CNT_QAM16, 1'b0}},
            '{sdm_pkg::MOD_QAM64, 16'sh8000, 16'sh8000, 1'b1, 1'b1,
              '{'{16'sd4096, 16'sd4096, 16'sd3464, 16'sd3464, 16'sd3148, 16'sd3148},
                sdm_pkg::CNT_QAM64, 1'b1}},
            '{sdm_pkg::MOD_QAM64, 16'sd0, 16'sd0, 1'b0, 1'b0, none},
            // 64QAM amplitude and inner boundaries near 5056, 2528 and 7584
            '{sdm_pkg::MOD_QAM64, 16'sd5056, -16'sd5057, 1'b0, 1'b0, none},
            '{sdm_pkg::MOD_QAM64, 16'sd2528, -16'sd7584, 1'b0, 1'b0, none},
            '{sdm_pkg::MOD_QAM64, 16'sh7fff, -16'sd1, 1'b0, 1'b0, none},
            '{sdm_pkg::MOD_QAM64, 16'sd7585, -16'sd2529, 1'b1, 1'b0, none}
        };

        // Hold reset, then release it away from the rising edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].mode != mod_cfg)
                write_modulation(dir_tab[i].mode);
            send_symbol(dir_tab[i].re, dir_tab[i].im, dir_tab[i].last,
                        dir_tab[i].typed, dir_tab[i].want);
        end

        // Random phases: every mode once in a fixed order, then random picks
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: m = sdm_pkg::MOD_QAM64;
                1: m = sdm_pkg::MOD_BPSK;
                2: m = sdm_pkg::MOD_QAM16;
                3: m = sdm_pkg::MOD_QPSK;
                default: m = sdm_pkg::mod_t'(2'($urandom_range(0, 3)));
            endcase
            write_modulation(m);
            for (int n = 0; n < PHASE_LEN; n++)
                send_symbol(pick_axis(), pick_axis(), ($urandom_range(0, 7) == 0), 1'b0, none);
        end

        // Drop valid, drain the pipe, then give stray words time to show up
        in_valid <= 1'b0;
        while (soft_bits_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (n_fail == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Receiver: random stalls per word, long hold-offs to back the pipe up, and the checks
    initial
    begin
        int         stall_len;
        int         n_rcvd;
        bit         calm;
        soft_word_t got;
        soft_word_t want;

        n_rcvd = 0;
        calm   = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            stall_len = calm ? 0 : $urandom_range(0, 11);
            // Go quiet for a long stretch while the sender keeps offering symbols
            if (n_rcvd == HOLD_AT_A || n_rcvd == HOLD_AT_B)
                stall_len = HOLD_LEN;
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(negedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!out_valid);
            n_rcvd++;
            got.llr  = {llr_0, llr_1, llr_2, llr_3, llr_4, llr_5};
            got.cnt  = llr_count;
            got.last = last_out;
            if (soft_bits_due.size() == 0)
            begin
                note_fail("unexpected word, llr_0", 64'sd0, longint'($signed(got.llr[0])));
            end
            else
            begin
                want = soft_bits_due.pop_front();
                for (int k = 0; k < 6; k++)
                    if (got.llr[k] !== want.llr[k])
                        note_fail($sformatf("llr_%0d", k), longint'($signed(want.llr[k])),
                                  longint'($signed(got.llr[k])));
                if (got.cnt !== want.cnt)
                    note_fail("llr_count", longint'(want.cnt), longint'(got.cnt));
                if (got.last !== want.last)
                    note_fail("last_out", longint'(want.last), longint'(got.last));
            end
            @(negedge clk);
        end
    end

endmodule
